// ===== sv/psnr_pkg.sv =====
// psnr_pkg: shared types, widths and constants for the image PSNR engine.
// No dependencies; imported by every module of the block.
`default_nettype none

package psnr_pkg;

  // Largest pixel count per image.
  localparam int MAX_PIXELS = 65536;
  localparam int PIX_W      = $clog2(MAX_PIXELS + 1);

  // 3 channels * 255^2: scales the pixel count to the peak-power numerator.
  localparam int N_SCALE = 195075;
  localparam int NS_W    = 18;

  // Width of the error sum and of the scaled count (same upper bound).
  localparam int VAL_W  = $clog2(64'(MAX_PIXELS) * 64'(N_SCALE) + 64'd1);
  // Width seen by the log unit: at least one full mantissa.
  localparam int NORM_W = (VAL_W > 32) ? VAL_W : 32;

  localparam int MANT_W = 32;
  localparam int FRAC_W = 24;
  localparam int EXP_W  = $clog2(NORM_W);
  localparam int LOG_W  = EXP_W + FRAC_W;
  localparam int CNT_W  = 5;

  localparam int SQ_W   = 16;
  localparam int SUM3_W = SQ_W + 2;

  // 256*10*log10(2) in Q.16.
  localparam int K_W = 26;
  localparam logic [K_W-1:0] PSNR_K = K_W'(50504453);
  localparam int PROD_W = LOG_W + K_W;
  localparam int RND_SH = 40;
  localparam int Q_W    = PROD_W + 1 - RND_SH;

  localparam int PSNR_W = 15;
  localparam logic [PSNR_W-1:0] PSNR_MAX = PSNR_W'(32767);

  typedef struct packed {
    logic [7:0] a_blue;
    logic [7:0] a_green;
    logic [7:0] a_red;
    logic [7:0] b_blue;
    logic [7:0] b_green;
    logic [7:0] b_red;
    logic       last_pixel;
  } psnr_in_t;

  typedef struct packed {
    logic [PSNR_W-1:0] psnr_db;
    logic              exact_match;
  } psnr_out_t;

  // Log unit status back to the controller.
  typedef struct packed {
    logic             done;
    logic [LOG_W-1:0] value;
  } psnr_lg_res_t;

  typedef enum logic [1:0] {
    LG_IDLE,
    LG_NORM,
    LG_SQR
  } psnr_lg_state_t;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_MUL,
    ST_LOGS,
    ST_LOGW,
    ST_SCALE,
    ST_FIN
  } psnr_state_t;

endpackage

`default_nettype wire

// ===== sv/image_psnr_engine_unit.sv =====
// image_psnr_engine_unit: streaming PSNR of two 8-bit BGR images, Q7.8 dB result.
// Throughput: one pixel pair per cycle while accumulating; after a last pixel the input
//   stalls until the result is loaded, longer while an earlier result still waits on out_stall.
// Reset: rst_n synchronous active low; clears the sum, the count, the FSM and out_valid.
// Depends on psnr_pkg, psnr_lane, psnr_log2.
`default_nettype none

module image_psnr_engine_unit (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire psnr_pkg::psnr_in_t  in_req,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output psnr_pkg::psnr_out_t      out_req
);
  import psnr_pkg::*;

  // ---------------------------------------------------------------------
  // Stage 1: three channel lanes, one squared difference each
  // ---------------------------------------------------------------------
  logic            in_accept;
  logic            s1_valid_r, s1_last_r;
  logic [SQ_W-1:0] sq_blue, sq_green, sq_red;

  assign in_accept = in_valid && !in_stall;

  psnr_lane u_lane_blue (
    .clk  (clk),
    .en   (in_accept),
    .a    (in_req.a_blue),
    .b    (in_req.b_blue),
    .sq_r (sq_blue)
  );

  psnr_lane u_lane_green (
    .clk  (clk),
    .en   (in_accept),
    .a    (in_req.a_green),
    .b    (in_req.b_green),
    .sq_r (sq_green)
  );

  psnr_lane u_lane_red (
    .clk  (clk),
    .en   (in_accept),
    .a    (in_req.a_red),
    .b    (in_req.b_red),
    .sq_r (sq_red)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_last_r <= in_req.last_pixel;
    end
  end

  // ---------------------------------------------------------------------
  // Merge stage: lane sum into the accumulator, plus the result FSM
  // ---------------------------------------------------------------------
  psnr_state_t       state_r, state_nxt;
  logic [VAL_W-1:0]  err_r, err_nxt;
  logic [PIX_W-1:0]  cnt_r, cnt_nxt;
  logic [NORM_W-1:0] n_r, n_nxt;
  logic [NORM_W-1:0] d_r, d_nxt;
  logic              zero_r, zero_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              out_valid_r, out_valid_nxt;
  psnr_out_t         out_req_r, out_req_nxt;

  logic [SUM3_W-1:0]      sum3;
  logic [PIX_W+NS_W-1:0]  n_full;
  logic [LOG_W-1:0]       diff;
  logic [PROD_W:0]        rnd;
  logic [Q_W-1:0]         q_full;
  logic [PSNR_W-1:0]      q_sat;
  logic                   lg_start;
  psnr_lg_res_t           lg_n, lg_d;

  // Hold off new pixels while a last pixel is being folded in or the result is built.
  assign in_stall = (state_r != ST_ACC) || (s1_valid_r && s1_last_r);
  assign lg_start = (state_r == ST_LOGS);

  psnr_log2 u_log_n (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lg_start),
    .value (n_r),
    .res   (lg_n)
  );

  psnr_log2 u_log_d (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lg_start),
    .value (d_r),
    .res   (lg_d)
  );

  always_comb begin
    sum3   = SUM3_W'(sq_blue) + SUM3_W'(sq_green) + SUM3_W'(sq_red);
    n_full = (PIX_W+NS_W)'(cnt_r) * (PIX_W+NS_W)'(N_SCALE);
    // log2(N) - log2(D), clamped at zero
    diff   = (lg_n.value > lg_d.value) ? (lg_n.value - lg_d.value) : '0;
    rnd    = (PROD_W+1)'(prod_r) + ((PROD_W+1)'(1) << (RND_SH - 1));
    q_full = rnd[PROD_W:RND_SH];
    q_sat  = (q_full > Q_W'(PSNR_MAX)) ? PSNR_MAX : q_full[PSNR_W-1:0];

    state_nxt     = state_r;
    err_nxt       = err_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    zero_nxt      = zero_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    out_req_nxt   = out_req_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_ACC: begin
        if (s1_valid_r) begin
          // a full count holds; a last marker still closes the image
          if (cnt_r < PIX_W'(MAX_PIXELS)) begin
            err_nxt = err_r + VAL_W'(sum3);
            cnt_nxt = cnt_r + 1'b1;
          end
          if (s1_last_r) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        n_nxt     = NORM_W'(n_full);
        d_nxt     = NORM_W'(err_r);
        zero_nxt  = (err_r == '0);
        err_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_LOGS;
      end
      ST_LOGS: begin
        state_nxt = ST_LOGW;
      end
      ST_LOGW: begin
        if (lg_n.done) begin
          state_nxt = ST_SCALE;
        end
      end
      ST_SCALE: begin
        prod_nxt  = PROD_W'(diff) * PROD_W'(PSNR_K);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // load only once the output register is free or draining
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_req_nxt.exact_match = zero_r;
          out_req_nxt.psnr_db     = zero_r ? '0 : q_sat;
          state_nxt               = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      err_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r       <= n_nxt;
    d_r       <= d_nxt;
    zero_r    <= zero_nxt;
    prod_r    <= prod_nxt;
    out_req_r <= out_req_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= PIX_W'(MAX_PIXELS))
    else $error("pixel count above limit");

  a_err_needs_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r != '0) |-> (cnt_r != '0))
    else $error("error sum without pixels");

  a_log_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    lg_n.done == lg_d.done)
    else $error("log units out of step");

  a_clear_after_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |=> (err_r == '0) && (cnt_r == '0))
    else $error("accumulator not cleared after image close");

  a_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_req_r.exact_match) |-> (out_req_r.psnr_db == '0))
    else $error("exact match with nonzero psnr");

endmodule

`default_nettype wire

// ===== sv/psnr_lane.sv =====
// psnr_lane: one channel lane, registered squared difference of two 8-bit samples.
// Depends on psnr_pkg.
`default_nettype none

module psnr_lane (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [7:0]              a,
  input  wire logic [7:0]              b,
  output logic [psnr_pkg::SQ_W-1:0]    sq_r
);
  import psnr_pkg::*;

  logic [7:0]      diff;
  logic [SQ_W-1:0] sq_nxt;

  always_comb begin
    diff   = (a > b) ? (a - b) : (b - a);
    sq_nxt = SQ_W'(diff) * SQ_W'(diff);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/psnr_log2.sv =====
// psnr_log2: iterative log2 in Q.FRAC_W, truncated.
// Binary-search normalization, then one mantissa squaring per cycle. Depends on psnr_pkg.
`default_nettype none

module psnr_log2 (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [psnr_pkg::NORM_W-1:0] value,
  output psnr_pkg::psnr_lg_res_t           res
);
  import psnr_pkg::*;

  psnr_lg_state_t      state_r, state_nxt;
  logic [NORM_W-1:0]   x_r, x_nxt;
  logic [EXP_W-1:0]    sh_r, sh_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [MANT_W-1:0]   mant_r, mant_nxt;
  logic [FRAC_W-1:0]   frac_r, frac_nxt;
  logic                done_r, done_nxt;
  logic [LOG_W-1:0]    value_r, value_nxt;

  logic [EXP_W-1:0]    amt;
  logic [EXP_W:0]      top_sh;
  logic                top_zero;
  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sq_t;
  logic [EXP_W-1:0]    expo;

  always_comb begin
    amt       = EXP_W'(1) << cnt_r;
    top_sh    = (EXP_W+1)'(NORM_W) - (EXP_W+1)'(amt);
    top_zero  = ((x_r >> top_sh) == '0);
    sq        = (2*MANT_W)'(mant_r) * (2*MANT_W)'(mant_r);
    sq_t      = sq[2*MANT_W-1:MANT_W-1];
    expo      = EXP_W'(NORM_W - 1) - sh_r;

    state_nxt = state_r;
    x_nxt     = x_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    mant_nxt  = mant_r;
    frac_nxt  = frac_r;
    done_nxt  = 1'b0;
    value_nxt = value_r;

    case (state_r)
      LG_IDLE: begin
        if (start) begin
          x_nxt     = value;
          sh_nxt    = '0;
          cnt_nxt   = CNT_W'(EXP_W - 1);
          state_nxt = LG_NORM;
        end
      end
      LG_NORM: begin
        if (top_zero) begin
          x_nxt  = x_r << amt;
          sh_nxt = sh_r + amt;
        end
        if (cnt_r == '0) begin
          mant_nxt  = x_nxt[NORM_W-1 -: MANT_W];
          frac_nxt  = '0;
          cnt_nxt   = CNT_W'(FRAC_W - 1);
          state_nxt = LG_SQR;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      LG_SQR: begin
        // squared mantissa >= 2 sets this fraction bit and renormalizes
        if (sq_t[MANT_W]) begin
          mant_nxt = sq_t[MANT_W:1];
        end else begin
          mant_nxt = sq_t[MANT_W-1:0];
        end
        frac_nxt = {frac_r[FRAC_W-2:0], sq_t[MANT_W]};
        if (cnt_r == '0) begin
          value_nxt = {expo, frac_nxt};
          done_nxt  = 1'b1;
          state_nxt = LG_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      default: begin
        state_nxt = LG_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LG_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r     <= x_nxt;
    sh_r    <= sh_nxt;
    cnt_r   <= cnt_nxt;
    mant_r  <= mant_nxt;
    frac_r  <= frac_nxt;
    value_r <= value_nxt;
  end

  assign res.done  = done_r;
  assign res.value = value_r;

endmodule

`default_nettype wire
